>>> sv/tsg_pkg.sv
package tsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	// divider dividend: split product or a shifted edge delta, whichever is wider
	localparam int PROD_W = 2 * (COORD_BITS + 1);
	localparam int SLOPE_W = COORD_BITS + 1 + FRAC_BITS;
	localparam int DIV_W = (PROD_W > SLOPE_W) ? PROD_W : SLOPE_W;
	localparam int DIV_WE = DIV_W + (DIV_W % 2);

	localparam int STEP_W = SLOPE_W;
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

	localparam int IN_FIELDS_W = 6 * COORD_BITS + 32;
	localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 * COORD_BITS + 32;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ROW  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] delta_t;

endpackage

>>> sv/triangle_scanline_span_generator.sv
// channel  dir  tdata                                       tuser    tlast
// s_*      in   a_x, a_y, b_x, b_y, c_x, c_y, fill_colour   command  -
// m_*      out  row_y, span_left_end, span_right_end,       -        last_span
//               span_colour
// Load transaction: sort states ST_SORT_A/B/C, a class state and a multiply, then split and two slope
// divisions on one shared 2-bit-per-cycle divider; an all-flat triangle is done after the
// class state.
// Row transaction: the row that ends the flat-bottom half adds two
// divisions for the flat-top slopes.
// s_tready is low while the sequencer works or an unaccepted span is held.
// arst_n clears state; no triangle is pending after reset.
module triangle_scanline_span_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, fill_colour
	input  logic [tsg_pkg::IN_DATA_W-1:0]       s_tdata,
	// command
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// row_y, span_left_end, span_right_end, span_colour, zero pad
	output logic [tsg_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                m_tlast
);

	localparam int CB = tsg_pkg::COORD_BITS;
	localparam int FB = tsg_pkg::FRAC_BITS;
	localparam int AW = tsg_pkg::ACC_W;
	localparam int IW = AW - FB;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SORT_A, ST_SORT_B, ST_SORT_C, ST_CLASS, ST_MUL, ST_DIV_START, ST_DIV_WAIT
	} state_t;

	typedef enum logic [1:0] {PH_IDLE, PH_BOTTOM, PH_TOP, PH_FLAT} phase_t;
	typedef enum logic [1:0] {DV_SPLIT, DV_LEFT, DV_RIGHT} div_sel_t;

	state_t state_q;
	phase_t phase_q;
	div_sel_t div_sel_q;
	logic top_q;

	tsg_pkg::coord_t vx_q [3];
	tsg_pkg::coord_t vy_q [3];
	tsg_pkg::coord_t split_x_q, row_q;
	logic [31:0] colour_q;
	logic signed [AW-1:0] left_acc_q, right_acc_q;
	logic signed [tsg_pkg::STEP_W-1:0] left_step_q, right_step_q;
	logic signed [tsg_pkg::PROD_W-1:0] prod_q;

	logic m_tvalid_q, m_tlast_q;
	logic [tsg_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic in_take, out_free, span_take, span_last;
	logic [1:0] lo_idx, hi_idx;
	logic swap;
	tsg_pkg::coord_t min_x, max_x, left_int, right_int;
	tsg_pkg::delta_t dx_sel, dy_sel;
	logic signed [tsg_pkg::DIV_W-1:0] div_dividend, div_quotient;
	logic div_start, div_done;

	function automatic tsg_pkg::delta_t diff(tsg_pkg::coord_t a, tsg_pkg::coord_t b);
		return $signed({a[CB-1], a}) - $signed({b[CB-1], b});
	endfunction

	function automatic logic signed [AW-1:0] fix(tsg_pkg::coord_t x);
		return $signed({{(AW-FB-CB){x[CB-1]}}, x, {FB{1'b0}}});
	endfunction

	// truncate toward zero, then clamp to the coordinate range
	function automatic tsg_pkg::coord_t sat_int(logic signed [AW-1:0] a);
		logic signed [IW-1:0] ip;
		logic signed [IW-1:0] cmax;
		logic signed [IW-1:0] cmin;
		ip = a[AW-1:FB];
		cmax = IW'({1'b0, {(CB-1){1'b1}}});
		cmin = -cmax - IW'(1);
		if (a[AW-1] && (|a[FB-1:0]))
			ip = ip + IW'(1);
		if (ip > cmax)
			ip = cmax;
		if (ip < cmin)
			ip = cmin;
		return ip[CB-1:0];
	endfunction

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_take = s_tvalid && s_tready;
	assign span_take = in_take && (s_tuser == tsg_pkg::CMD_ROW) && (phase_q != PH_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

	always_comb begin
		lo_idx = (state_q == ST_SORT_B) ? 2'd1 : 2'd0;
		hi_idx = lo_idx + 2'd1;
		swap = vy_q[lo_idx] > vy_q[hi_idx];

		min_x = vx_q[0];
		max_x = vx_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < min_x)
				min_x = vx_q[i];
			if (vx_q[i] > max_x)
				max_x = vx_q[i];
		end

		left_int = sat_int(left_acc_q);
		right_int = sat_int(right_acc_q);

		case (phase_q)
			PH_FLAT: span_last = 1'b1;
			PH_BOTTOM: span_last = (row_q >= vy_q[1]) && (vy_q[1] == vy_q[2]);
			PH_TOP: span_last = (row_q <= vy_q[1]);
			default: span_last = 1'b0;
		endcase

		case (div_sel_q)
			DV_SPLIT: dy_sel = diff(vy_q[2], vy_q[0]);
			default: dy_sel = top_q ? diff(vy_q[2], vy_q[1]) : diff(vy_q[1], vy_q[0]);
		endcase
		case (div_sel_q)
			DV_LEFT: begin
				if (!top_q)
					dx_sel = diff(vx_q[1], vx_q[0]);
				else if (vy_q[0] == vy_q[1])
					dx_sel = diff(vx_q[0], vx_q[2]);
				else
					dx_sel = diff(vx_q[1], vx_q[2]);
			end
			DV_RIGHT: begin
				if (!top_q)
					dx_sel = diff(split_x_q, vx_q[0]);
				else if (vy_q[0] == vy_q[1])
					dx_sel = diff(vx_q[1], vx_q[2]);
				else
					dx_sel = diff(split_x_q, vx_q[2]);
			end
			default: dx_sel = '0;
		endcase
		if (div_sel_q == DV_SPLIT)
			div_dividend = tsg_pkg::DIV_W'(prod_q);
		else
			div_dividend = tsg_pkg::DIV_W'($signed({dx_sel, {FB{1'b0}}}));
	end

	assign div_start = (state_q == ST_DIV_START);

	tsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (dy_sel[CB-1:0]),
		.quotient (div_quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			div_sel_q <= DV_SPLIT;
			top_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
			split_x_q <= '0;
			row_q <= '0;
			colour_q <= '0;
			left_acc_q <= '0;
			right_acc_q <= '0;
			left_step_q <= '0;
			right_step_q <= '0;
			prod_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (span_take)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take && s_tuser == tsg_pkg::CMD_LOAD) begin
						vx_q[0] <= s_tdata[CB-1:0];
						vy_q[0] <= s_tdata[2*CB-1:CB];
						vx_q[1] <= s_tdata[3*CB-1:2*CB];
						vy_q[1] <= s_tdata[4*CB-1:3*CB];
						vx_q[2] <= s_tdata[5*CB-1:4*CB];
						vy_q[2] <= s_tdata[6*CB-1:5*CB];
						colour_q <= s_tdata[6*CB+31:6*CB];
						phase_q <= PH_IDLE;
						state_q <= ST_SORT_A;
					end else if (span_take) begin
						m_tdata_q <= tsg_pkg::OUT_DATA_W'({colour_q, right_int, left_int, row_q});
						m_tlast_q <= span_last;
						case (phase_q)
							PH_FLAT: begin
								phase_q <= PH_IDLE;
							end
							PH_BOTTOM: begin
								if (row_q >= vy_q[1]) begin
									if (vy_q[1] == vy_q[2]) begin
										phase_q <= PH_IDLE;
									end else begin
										top_q <= 1'b1;
										div_sel_q <= DV_LEFT;
										state_q <= ST_DIV_START;
									end
								end else begin
									left_acc_q <= left_acc_q + AW'(left_step_q);
									right_acc_q <= right_acc_q + AW'(right_step_q);
									row_q <= row_q + 1'b1;
								end
							end
							default: begin
								if (row_q <= vy_q[1]) begin
									phase_q <= PH_IDLE;
								end else begin
									left_acc_q <= left_acc_q + AW'(left_step_q);
									right_acc_q <= right_acc_q + AW'(right_step_q);
									row_q <= row_q - 1'b1;
								end
							end
						endcase
					end
				end
				ST_SORT_A, ST_SORT_B, ST_SORT_C: begin
					if (swap) begin
						vx_q[lo_idx] <= vx_q[hi_idx];
						vy_q[lo_idx] <= vy_q[hi_idx];
						vx_q[hi_idx] <= vx_q[lo_idx];
						vy_q[hi_idx] <= vy_q[lo_idx];
					end
					if (state_q == ST_SORT_A)
						state_q <= ST_SORT_B;
					else if (state_q == ST_SORT_B)
						state_q <= ST_SORT_C;
					else
						state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (vy_q[2] == vy_q[0]) begin
						split_x_q <= vx_q[0];
						left_acc_q <= fix(min_x);
						right_acc_q <= fix(max_x);
						left_step_q <= '0;
						right_step_q <= '0;
						row_q <= vy_q[0];
						phase_q <= PH_FLAT;
						state_q <= ST_IDLE;
					end else begin
						top_q <= (vy_q[0] == vy_q[1]);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= diff(vx_q[2], vx_q[0]) * diff(vy_q[1], vy_q[0]);
					div_sel_q <= DV_SPLIT;
					state_q <= ST_DIV_START;
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						case (div_sel_q)
							DV_SPLIT: begin
								split_x_q <= div_quotient[CB-1:0] + vx_q[0];
								div_sel_q <= DV_LEFT;
								state_q <= ST_DIV_START;
							end
							DV_LEFT: begin
								left_step_q <= div_quotient[tsg_pkg::STEP_W-1:0];
								div_sel_q <= DV_RIGHT;
								state_q <= ST_DIV_START;
							end
							default: begin
								right_step_q <= div_quotient[tsg_pkg::STEP_W-1:0];
								if (top_q) begin
									left_acc_q <= fix(vx_q[2]);
									right_acc_q <= fix(vx_q[2]);
									row_q <= vy_q[2];
									phase_q <= PH_TOP;
								end else begin
									left_acc_q <= fix(vx_q[0]);
									right_acc_q <= fix(vx_q[0]);
									row_q <= vy_q[0];
									phase_q <= PH_BOTTOM;
								end
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && phase_q != PH_IDLE) |-> (vy_q[0] <= vy_q[1] && vy_q[1] <= vy_q[2]))
		else $error("pending triangle not sorted by y");

	a_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && phase_q == PH_BOTTOM) |-> (row_q >= vy_q[0] && row_q <= vy_q[1]))
		else $error("flat-bottom row out of range");

	a_top_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && phase_q == PH_TOP) |-> (row_q >= vy_q[1] && row_q <= vy_q[2]))
		else $error("flat-top row out of range");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider result with no division pending");

	a_span_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_take && s_tuser == tsg_pkg::CMD_ROW))
		else $error("span issued without a row transaction");

endmodule

>>> sv/tsg_div.sv
module tsg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tsg_pkg::DIV_W-1:0]  dividend,
	input  logic [tsg_pkg::COORD_BITS-1:0]    divisor,
	output logic signed [tsg_pkg::DIV_W-1:0]  quotient,
	output logic                              done
);

	localparam int N = tsg_pkg::DIV_WE;
	localparam int CB = tsg_pkg::COORD_BITS;
	localparam int RW = CB + 1;
	localparam int STEPS = N / 2;
	localparam int CW = $clog2(STEPS + 1);

	logic [RW-1:0] rem_q, rem_n;
	logic [N-1:0] quo_q, quo_n, mag;
	logic [CB-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, busy_q, done_q;
	logic [RW:0] sh;
	logic signed [N-1:0] dvd_ext, res;

	always_comb begin
		dvd_ext = N'(dividend);
		mag = dvd_ext[N-1] ? N'(-dvd_ext) : N'(dvd_ext);
		rem_n = rem_q;
		quo_n = quo_q;
		sh = '0;
		// two restoring steps per cycle
		for (int k = 0; k < 2; k++) begin
			sh = {rem_n, quo_n[N-1]};
			quo_n = {quo_n[N-2:0], 1'b0};
			if (sh >= (RW+1)'(dvs_q)) begin
				sh = sh - (RW+1)'(dvs_q);
				quo_n[0] = 1'b1;
			end
			rem_n = sh[RW-1:0];
		end
		res = neg_q ? -$signed(quo_q) : $signed(quo_q);
	end

	assign quotient = res[tsg_pkg::DIV_W-1:0];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= divisor;
			neg_q <= dvd_ext[N-1];
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

endmodule

>>> test/triangle_span_checker.sv
module triangle_span_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tsg_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tsg_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             spans_pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = tsg_pkg::COORD_BITS;
	localparam int FB = tsg_pkg::FRAC_BITS;
	localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef enum logic [1:0] {WALK_IDLE, WALK_DOWN, WALK_UP, WALK_FLAT} walk_t;

	typedef struct {
		tsg_pkg::coord_t row;
		tsg_pkg::coord_t left;
		tsg_pkg::coord_t right;
		logic [31:0]     colour;
		logic            last;
	} span_t;

	span_t       expected_spans[$];
	int          vx[3];
	int          vy[3];
	int          split_x;
	longint      left_acc;
	longint      right_acc;
	longint      left_step;
	longint      right_step;
	int          cur_row;
	walk_t       walk;
	logic [31:0] colour_held;

	function automatic longint to_fixed(int x);
		return longint'(x) <<< FB;
	endfunction

	function automatic longint edge_slope(int dx, int dy);
		if (dy == 0)
			return 0;
		return to_fixed(dx) / longint'(dy);
	endfunction

	// truncate toward zero, then clamp to the coordinate range
	function automatic tsg_pkg::coord_t walker_x(longint acc);
		longint r;
		r = (acc < 0) ? -((-acc) >>> FB) : (acc >>> FB);
		if (r > CMAX)
			r = CMAX;
		if (r < CMIN)
			r = CMIN;
		return tsg_pkg::coord_t'(r);
	endfunction

	task automatic begin_upper(int lx, int rx);
		left_step  = edge_slope(lx - vx[2], vy[2] - vy[1]);
		right_step = edge_slope(rx - vx[2], vy[2] - vy[1]);
		left_acc   = to_fixed(vx[2]);
		right_acc  = to_fixed(vx[2]);
		cur_row    = vy[2];
		walk       = WALK_UP;
	endtask

	task automatic load_triangle(logic [tsg_pkg::IN_DATA_W-1:0] d);
		tsg_pkg::coord_t c;
		int     v[6];
		int     t;
		int     lo;
		int     hi;
		for (int i = 0; i < 6; i++) begin
			c = d[i*CB +: CB];
			v[i] = c;
		end
		if (v[1] > v[3]) begin
			t = v[0]; v[0] = v[2]; v[2] = t;
			t = v[1]; v[1] = v[3]; v[3] = t;
		end
		if (v[3] > v[5]) begin
			t = v[2]; v[2] = v[4]; v[4] = t;
			t = v[3]; v[3] = v[5]; v[5] = t;
		end
		if (v[1] > v[3]) begin
			t = v[0]; v[0] = v[2]; v[2] = t;
			t = v[1]; v[1] = v[3]; v[3] = t;
		end
		for (int i = 0; i < 3; i++) begin
			vx[i] = v[2*i];
			vy[i] = v[2*i+1];
		end
		colour_held = d[6*CB +: 32];
		if (vy[2] == vy[0]) begin
			lo = vx[0];
			hi = vx[0];
			for (int i = 1; i < 3; i++) begin
				if (vx[i] < lo)
					lo = vx[i];
				if (vx[i] > hi)
					hi = vx[i];
			end
			split_x    = vx[0];
			left_acc   = to_fixed(lo);
			right_acc  = to_fixed(hi);
			left_step  = 0;
			right_step = 0;
			cur_row    = vy[0];
			walk       = WALK_FLAT;
		end else begin
			split_x = ((vx[2] - vx[0]) * (vy[1] - vy[0])) / (vy[2] - vy[0]) + vx[0];
			if (vy[0] == vy[1]) begin
				begin_upper(vx[0], vx[1]);
			end else begin
				left_step  = edge_slope(vx[1] - vx[0], vy[1] - vy[0]);
				right_step = edge_slope(split_x - vx[0], vy[1] - vy[0]);
				left_acc   = to_fixed(vx[0]);
				right_acc  = to_fixed(vx[0]);
				cur_row    = vy[0];
				walk       = WALK_DOWN;
			end
		end
	endtask

	task automatic advance_walk(output span_t s);
		s.row    = tsg_pkg::coord_t'(cur_row);
		s.left   = walker_x(left_acc);
		s.right  = walker_x(right_acc);
		s.colour = colour_held;
		s.last   = 1'b0;
		case (walk)
			WALK_FLAT: begin
				s.last = 1'b1;
				walk = WALK_IDLE;
			end
			WALK_DOWN: begin
				if (cur_row >= vy[1]) begin
					if (vy[1] == vy[2]) begin
						s.last = 1'b1;
						walk = WALK_IDLE;
					end else begin
						begin_upper(vx[1], split_x);
					end
				end else begin
					left_acc += left_step;
					right_acc += right_step;
					cur_row++;
				end
			end
			default: begin
				if (cur_row <= vy[1]) begin
					s.last = 1'b1;
					walk = WALK_IDLE;
				end else begin
					left_acc += left_step;
					right_acc += right_step;
					cur_row--;
				end
			end
		endcase
	endtask

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		span_t  want;
		span_t  made;
		tsg_pkg::coord_t got;
		if (!arst_n) begin
			expected_spans.delete();
			vx = '{0, 0, 0};
			vy = '{0, 0, 0};
			split_x = 0;
			left_acc = 0;
			right_acc = 0;
			left_step = 0;
			right_step = 0;
			cur_row = 0;
			walk = WALK_IDLE;
			colour_held = '0;
			mismatches = 0;
			spans_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_spans.size() == 0) begin
					$display("%0t: unexpected span transaction, expected none actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = expected_spans.pop_front();
					got = m_tdata[0 +: CB];
					check_field("row_y", want.row, got);
					got = m_tdata[CB +: CB];
					check_field("span_left_end", want.left, got);
					got = m_tdata[2*CB +: CB];
					check_field("span_right_end", want.right, got);
					check_field("span_colour", want.colour, m_tdata[3*CB +: 32]);
					check_field("last_span", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == tsg_pkg::CMD_LOAD) begin
					load_triangle(s_tdata);
				end else if (walk != WALK_IDLE) begin
					advance_walk(made);
					expected_spans.push_back(made);
				end
			end
			spans_pending = expected_spans.size();
		end
	end

endmodule

>>> test/triangle_scanline_span_generator_test.sv
module triangle_scanline_span_generator_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB          = tsg_pkg::COORD_BITS;
	localparam int ITEM_TARGET = 1650;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_OFF    = 400;
	localparam int DRAIN       = 100;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [tsg_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [tsg_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;
	int                             mismatches;
	int                             spans_pending;
	int                             items_sent;
	int                             tx_left;
	bit                             tx_quiet;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	triangle_scanline_span_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	triangle_span_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.spans_pending (spans_pending)
	);

	// bursts of back-to-back traffic alternate with random gaps
	function automatic int draw_gap(ref int left, ref bit quiet);
		if (left == 0) begin
			left = $urandom_range(20, 60);
			quiet = ($urandom_range(0, 3) == 0);
		end
		left--;
		return quiet ? 0 : int'($urandom_range(0, 18));
	endfunction

	function automatic logic [tsg_pkg::IN_DATA_W-1:0] pack_triangle(int ax, int ay, int bx,
			int by, int cx, int cy, logic [31:0] colour);
		logic [tsg_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[0*CB +: CB] = tsg_pkg::coord_t'(ax);
		d[1*CB +: CB] = tsg_pkg::coord_t'(ay);
		d[2*CB +: CB] = tsg_pkg::coord_t'(bx);
		d[3*CB +: CB] = tsg_pkg::coord_t'(by);
		d[4*CB +: CB] = tsg_pkg::coord_t'(cx);
		d[5*CB +: CB] = tsg_pkg::coord_t'(cy);
		d[6*CB +: 32] = colour;
		return d;
	endfunction

	// rows a triangle yields: both halves share the middle row
	function automatic int span_rows(int ya, int yb, int yc);
		int lo;
		int hi;
		int mid;
		lo = (ya < yb) ? ya : yb;
		lo = (lo < yc) ? lo : yc;
		hi = (ya > yb) ? ya : yb;
		hi = (hi > yc) ? hi : yc;
		mid = ya + yb + yc - lo - hi;
		if (lo == hi)
			return 1;
		return ((mid != lo) ? mid - lo + 1 : 0) + ((hi != mid) ? hi - mid + 1 : 0);
	endfunction

	function automatic int pick_centre(int reach);
		return int'($urandom_range(0, 4095 - 2 * reach)) - 2048 + reach;
	endfunction

	task automatic send_word(logic cmd, logic [tsg_pkg::IN_DATA_W-1:0] d);
		int gap;
		gap = draw_gap(tx_left, tx_quiet);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_rows(int n);
		repeat (n) send_word(tsg_pkg::CMD_ROW,
			tsg_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
	endtask

	task automatic draw_triangle(int ax, int ay, int bx, int by, int cx, int cy,
			logic [31:0] colour, int rows);
		send_word(tsg_pkg::CMD_LOAD, pack_triangle(ax, ay, bx, by, cx, cy, colour));
		send_rows(rows);
	endtask

	task automatic random_triangle();
		int h;
		int w;
		int xc;
		int yc;
		int shape;
		int k;
		int t;
		int xs[3];
		int ys[3];
		int full;
		int rows;
		h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 10);
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
		xc = pick_centre(w);
		yc = pick_centre(h);
		shape = $urandom_range(0, 9);
		case (shape)
			0: ys = '{yc, yc, yc};
			1: ys = '{yc - h, yc, yc};
			2: ys = '{yc + h, yc, yc};
			default: ys = '{yc - h, yc - h + int'($urandom_range(0, 2 * h)), yc + h};
		endcase
		k = $urandom_range(0, 2);
		t = ys[0]; ys[0] = ys[k]; ys[k] = t;
		k = $urandom_range(1, 2);
		t = ys[1]; ys[1] = ys[k]; ys[k] = t;
		for (int i = 0; i < 3; i++)
			xs[i] = xc + int'($urandom_range(0, 2 * w)) - w;
		full = span_rows(ys[0], ys[1], ys[2]);
		if ($urandom_range(0, 99) < 85)
			rows = full + $urandom_range(0, 1);
		else
			rows = $urandom_range(0, full - 1);
		draw_triangle(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom, rows);
	endtask

	// screen-wide triangle, usually abandoned by the next load after at most 30 rows
	task automatic random_tall_triangle();
		int c[6];
		int rows;
		for (int i = 0; i < 6; i++)
			c[i] = int'($urandom_range(0, 4095)) - 2048;
		rows = $urandom_range(1, 30);
		if (rows > span_rows(c[1], c[3], c[5]))
			rows = span_rows(c[1], c[3], c[5]);
		draw_triangle(c[0], c[1], c[2], c[3], c[4], c[5], $urandom, rows);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = tsg_pkg::CMD_LOAD;
		s_tdata  = '0;
		m_tready = 1'b0;
		items_sent = 0;
		tx_left = 0;
		tx_quiet = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_rows(1);
		draw_triangle(5, 7, -3, 7, 12, 7, 32'h0000_0000, 2);
		draw_triangle(0, 0, 6, 1, -3, 2, 32'h1234_5678, 4);
		draw_triangle(0, 0, -5, 2, 5, 2, 32'hA5A5_5A5A, 3);
		draw_triangle(-5, 2047, 5, 2047, 0, 2045, 32'h8000_0001, 3);
		draw_triangle(-2048, -2048, 2047, 2047, 0, 0, 32'hFFFF_FFFF, 2);
		draw_triangle(-2048, -3, 2047, -1, 0, 1, 32'h7FFF_FFFE, 6);

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0: send_rows($urandom_range(1, 3));
				1: random_tall_triangle();
				default: random_triangle();
			endcase
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (spans_pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && spans_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// span consumer: random back-pressure, one long hold-off to fill the block
	initial begin
		int  gap;
		int  rx_left;
		bit  rx_quiet;
		int  spans_taken;
		rx_left = 0;
		rx_quiet = 1'b0;
		spans_taken = 0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(rx_left, rx_quiet);
			if (spans_taken == 100)
				gap = HOLD_OFF;
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			spans_taken++;
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
sv/tsg_pkg.sv
sv/tsg_div.sv
sv/triangle_scanline_span_generator.sv
test/triangle_span_checker.sv
test/triangle_scanline_span_generator_test.sv
